[hw/rtl/bfc_pkg.sv]
// bfc_pkg: shared types, constants and helpers for the box frustum cull unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bfc_pkg;

    // Geometry sizes
    localparam int NUM_PLANES = 6;
    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Fixed-point widths: Q11.4 coordinates and d, Q1.14 normals
    localparam int COORD_W    = 16;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int W_ONE_FRAC = 14;   // w = 1.0 in Q1.14

    // Axis codes
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    // Plane register layout: nx[63:48] ny[47:32] nz[31:16] d[15:0]
    typedef struct packed {
        coord_t nx;
        coord_t ny;
        coord_t nz;
        coord_t d;
    } plane_t;

    // Normal component of a plane along one axis
    function automatic coord_t plane_normal(input plane_t pl, input logic [AXIS_W-1:0] axis);
        coord_t n;
        unique case (axis)
            AXIS_X:  n = pl.nx;
            AXIS_Y:  n = pl.ny;
            AXIS_Z:  n = pl.nz;
            default: n = pl.nz;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bfc_select.sv]
// bfc_select: stage 1, picks per plane and axis the bound that minimizes n*coord.
// Depends on bfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfc_select
    import bfc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   valid_in,
    input  wire coord_t lo [AXES],
    input  wire coord_t hi [AXES],
    input  wire plane_t planes [NUM_PLANES],
    output logic        valid_reg,
    output coord_t      sel_reg [NUM_PLANES][AXES]
);

    coord_t sel_next [NUM_PLANES][AXES];

    // The minimizing corner: lower bound when the normal sign agrees with bound order
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                coord_t n;
                logic   ordered;
                n        = plane_normal(planes[p], AXIS_W'(a));
                ordered  = (lo[a] <= hi[a]);
                sel_next[p][a] = ((!n[COORD_W-1]) == ordered) ? lo[a] : hi[a];
            end
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    // Selected coordinates
    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
    end

endmodule

`default_nettype wire

[hw/rtl/bfc_mult.sv]
// bfc_mult: stage 2, one 16x16 signed multiplier per plane and axis.
// Depends on bfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfc_mult
    import bfc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   valid_in,
    input  wire coord_t sel [NUM_PLANES][AXES],
    input  wire plane_t planes [NUM_PLANES],
    output logic        valid_reg,
    output prod_t       prod_reg [NUM_PLANES][AXES]
);

    prod_t prod_next [NUM_PLANES][AXES];

    // Exact products, Q.18
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                prod_t n_ext;
                prod_t c_ext;
                n_ext = PROD_W'(plane_normal(planes[p], AXIS_W'(a)));
                c_ext = PROD_W'(sel[p][a]);
                prod_next[p][a] = n_ext * c_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

[hw/rtl/bfc_reduce.sv]
// bfc_reduce: stages 3 and 4, per-plane sum with the d term, then any-plane reduce.
// Depends on bfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfc_reduce
    import bfc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   valid_in,
    input  wire prod_t  prod [NUM_PLANES][AXES],
    input  wire plane_t planes [NUM_PLANES],
    output logic        valid_reg,
    output logic        outside_reg
);

    logic                  sum_valid_reg;
    logic [NUM_PLANES-1:0] empty_reg;
    logic [NUM_PLANES-1:0] empty_next;

    // Smallest corner sum per plane; plane has no corner in when it is >= 0
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            sum_t acc;
            sum_t d_term;
            d_term = sum_t'(planes[p].d) <<< W_ONE_FRAC;
            acc    = d_term;
            for (int a = 0; a < AXES; a++)
                acc = acc + sum_t'(prod[p][a]);
            empty_next[p] = !acc[SUM_W-1];
        end
    end

    // Valid bits for both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= valid_in;
            valid_reg     <= sum_valid_reg;
        end
    end

    // Plane flags, then the box verdict
    always_ff @(posedge clk)
    begin
        empty_reg   <= empty_next;
        outside_reg <= |empty_reg;
    end

endmodule

`default_nettype wire

[hw/rtl/box_frustum_cull_unit.sv]
// box_frustum_cull_unit: top level, plane registers and the four-stage cull pipeline.
// Depends on bfc_pkg, bfc_select, bfc_mult, bfc_reduce.
`timescale 1ns / 1ps
`default_nettype none

// Tests one axis-aligned box per clock against six frustum planes. A box is
// taken at every edge where start is high; busy is always low, so a box may
// follow in the next cycle. Its verdict appears on outside with done high for
// one cycle, after one register stage each for corner select, multiply, plane
// sum and the any-plane reduce. The result cannot be held off: sample it when
// done is high. Planes are written through cfg_we/cfg_idx/cfg_wdata; the user
// must write them only while no box is in flight, which the block does not
// enforce. Indexes 6 and 7 are ignored. After reset all planes are zero and
// every box reads outside.

module box_frustum_cull_unit
    import bfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire coord_t                min_x,
    input  wire coord_t                min_y,
    input  wire coord_t                min_z,
    input  wire coord_t                max_x,
    input  wire coord_t                max_y,
    input  wire coord_t                max_z,
    output logic                       done,
    output logic                       outside,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    plane_t plane_reg [NUM_PLANES];
    coord_t lo [AXES];
    coord_t hi [AXES];
    coord_t sel [NUM_PLANES][AXES];
    prod_t  prod [NUM_PLANES][AXES];
    logic   accept;
    logic   sel_valid;
    logic   mult_valid;

    // Pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign lo[0] = min_x;
    assign lo[1] = min_y;
    assign lo[2] = min_z;
    assign hi[0] = max_x;
    assign hi[1] = max_y;
    assign hi[2] = max_z;

    // Plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
                plane_reg[p] <= '0;
        end
        else
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                if (cfg_we && (cfg_idx == CFG_IDX_W'(p)))
                    plane_reg[p] <= plane_t'(cfg_wdata);
            end
        end
    end

    bfc_select u_select
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .lo        (lo),
        .hi        (hi),
        .planes    (plane_reg),
        .valid_reg (sel_valid),
        .sel_reg   (sel)
    );

    bfc_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sel_valid),
        .sel       (sel),
        .planes    (plane_reg),
        .valid_reg (mult_valid),
        .prod_reg  (prod)
    );

    bfc_reduce u_reduce
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_in    (mult_valid),
        .prod        (prod),
        .planes      (plane_reg),
        .valid_reg   (done),
        .outside_reg (outside)
    );

    // Every taken box yields exactly one result
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 mult_valid ##2 done)
        else $error("accepted box did not complete in four cycles");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("result strobe without a box taken four cycles earlier");

    a_mult_has_sel: assert property (@(posedge clk) disable iff (!rst_n)
        mult_valid |-> $past(sel_valid))
        else $error("multiply stage valid without select stage valid");

endmodule

`default_nettype wire

[test/box_frustum_cull_unit_tb.sv]
// box_frustum_cull_unit_tb: self-checking bench that pushes boxes through the cull unit
// under several plane sets and checks every verdict against an in-bench predictor.
// Depends on bfc_pkg and box_frustum_cull_unit.
`timescale 1ns / 1ps

module box_frustum_cull_unit_tb;
    import bfc_pkg::*;

    localparam int     CLK_HALF        = 5;
    localparam int     RST_CYCLES      = 9;
    localparam int     PIPE_LAT        = 4;
    localparam longint CYCLE_LIMIT     = 200000;
    localparam int     BOXES_PER_SET   = 66;
    localparam int     NUM_CORNERS     = 8;
    localparam int     CUBE_HALF       = 1600;   // 100.0 in Q11.4
    localparam logic [CFG_IDX_W-1:0] IDX_LAST_SLOT = 3'd7;   // slots 6 and 7 are unused
    localparam coord_t Q14_ONE         = 16'sd16384;

    typedef enum int {PLANES_SLAB, PLANES_SLANT, PLANES_RANDOM, PLANES_EXTREME} plane_kind_e;

    typedef struct packed {
        coord_t min_x, min_y, min_z, max_x, max_y, max_z;
    } box_t;

    typedef plane_t plane_set_t [NUM_PLANES];

    // DUT signals
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    coord_t                min_x     = '0;
    coord_t                min_y     = '0;
    coord_t                min_z     = '0;
    coord_t                max_x     = '0;
    coord_t                max_y     = '0;
    coord_t                max_z     = '0;
    logic                  done;
    logic                  outside;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Bench state
    box_t       box_queue[$];
    logic       verdict_queue[$];
    plane_set_t plane_shadow  = '{default: '0};
    box_t       next_box;
    int         idle_pct      = 0;
    bit         box_taken     = 1'b0;
    int         boxes_queued  = 0;
    int         boxes_taken   = 0;
    int         verdicts_seen = 0;
    int         culled_seen   = 0;
    int         cfg_writes    = 0;
    int         plane_sets    = 0;
    int         err_count     = 0;
    longint     cycle_count   = 0;

    box_frustum_cull_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .min_x     (min_x),
        .min_y     (min_y),
        .min_z     (min_z),
        .max_x     (max_x),
        .max_y     (max_y),
        .max_z     (max_z),
        .done      (done),
        .outside   (outside),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Predicted verdict: culled when some plane has no corner strictly below zero
    function automatic logic cull_verdict(input box_t b);
        coord_t lo[AXES];
        coord_t hi[AXES];
        longint acc;
        bit     any_in;
        logic   culled;
        int     p;
        int     c;
        lo[0] = b.min_x;
        lo[1] = b.min_y;
        lo[2] = b.min_z;
        hi[0] = b.max_x;
        hi[1] = b.max_y;
        hi[2] = b.max_z;
        culled = 1'b0;
        for (p = 0; p < NUM_PLANES; p++)
        begin
            any_in = 1'b0;
            for (c = 0; c < NUM_CORNERS; c++)
            begin
                acc = longint'(plane_shadow[p].nx) * longint'(c[0] ? hi[0] : lo[0])
                    + longint'(plane_shadow[p].ny) * longint'(c[1] ? hi[1] : lo[1])
                    + longint'(plane_shadow[p].nz) * longint'(c[2] ? hi[2] : lo[2])
                    + longint'(plane_shadow[p].d) * (longint'(1) <<< W_ONE_FRAC);
                if (acc < 0)
                    any_in = 1'b1;
            end
            if (!any_in)
                culled = 1'b1;
        end
        return culled;
    endfunction

    function automatic box_t mk_box(input int ax, ay, az, bx, by, bz);
        box_t b;
        b.min_x = COORD_W'(ax);
        b.min_y = COORD_W'(ay);
        b.min_z = COORD_W'(az);
        b.max_x = COORD_W'(bx);
        b.max_y = COORD_W'(by);
        b.max_z = COORD_W'(bz);
        return b;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // Mostly well-formed boxes near the origin, some inverted, some raw or extreme
    function automatic box_t rand_box();
        int sel, cx, cy, cz, ex, ey, ez;
        sel = $urandom_range(9);
        cx  = int'($urandom_range(6000)) - 3000;
        cy  = int'($urandom_range(6000)) - 3000;
        cz  = int'($urandom_range(6000)) - 3000;
        ex  = $urandom_range(1500);
        ey  = $urandom_range(1500);
        ez  = $urandom_range(1500);
        if (sel <= 5)
            return mk_box(cx - ex, cy - ey, cz - ez, cx + ex, cy + ey, cz + ez);
        else if (sel == 6)
            return mk_box(cx + ex, cy + ey, cz + ez, cx - ex, cy - ey, cz - ez);
        else if (sel <= 8)
            return box_t'({$urandom, $urandom, $urandom});
        else
            return mk_box(extreme_coord(), extreme_coord(), extreme_coord(),
                          extreme_coord(), extreme_coord(), extreme_coord());
    endfunction

    // Build one set of six planes; slab sets bound each axis at +/- half
    function automatic plane_set_t make_planes(input plane_kind_e kind, input int half);
        plane_set_t s;
        int         p;
        coord_t     n;
        for (p = 0; p < NUM_PLANES; p++)
        begin
            s[p] = '0;
            case (kind)
                PLANES_SLAB:
                begin
                    n      = p[0] ? -Q14_ONE : Q14_ONE;
                    s[p].d = COORD_W'(-half);
                    case (AXIS_W'(p / 2))
                        AXIS_X:  s[p].nx = n;
                        AXIS_Y:  s[p].ny = n;
                        default: s[p].nz = n;
                    endcase
                end
                PLANES_SLANT:
                begin
                    s[p].nx = COORD_W'(int'($urandom_range(32768)) - 16384);
                    s[p].ny = COORD_W'(int'($urandom_range(32768)) - 16384);
                    s[p].nz = COORD_W'(int'($urandom_range(32768)) - 16384);
                    s[p].d  = COORD_W'(int'($urandom_range(4000)) - 2000);
                end
                PLANES_RANDOM:
                    s[p] = {$urandom, $urandom};
                default:
                begin
                    case ($urandom_range(4))
                        0:       s[p] = 64'h8000_8000_8000_8000;
                        1:       s[p] = 64'h7FFF_7FFF_7FFF_7FFF;
                        2:       s[p] = 64'h7FFF_7FFF_7FFF_8000;
                        3:       s[p] = 64'h8000_8000_8000_7FFF;
                        default: s[p] = 64'h0;
                    endcase
                end
            endcase
        end
        return s;
    endfunction

    // Write all plane registers plus the two unused slots, then drop the enable
    task automatic program_planes(input plane_set_t set);
        int p;
        for (p = 0; p <= IDX_LAST_SLOT; p++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_idx   <= CFG_IDX_W'(p);
            cfg_wdata <= (p < NUM_PLANES) ? set[p] : {$urandom, $urandom};
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        plane_sets++;
    endtask

    task automatic queue_box(input box_t b);
        box_queue.push_back(b);
        boxes_queued++;
    endtask

    // Wait until every queued box was taken and its verdict checked
    task automatic wait_drained();
        while (!(boxes_taken == boxes_queued && verdict_queue.size() == 0))
            @(negedge clk);
        repeat (PIPE_LAT + 2) @(negedge clk);
    endtask

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d verdicts pending",
                     cycle_count, verdict_queue.size());
            $display("box_frustum_cull_unit test failed");
            $finish;
        end
    end

    // Driver: present the next box at the falling edge, hold it until the transfer
    always @(negedge clk)
    begin
        if (rst_n && !(start && !box_taken))
        begin
            if (box_queue.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                next_box = box_queue.pop_front();
                min_x <= next_box.min_x;
                min_y <= next_box.min_y;
                min_z <= next_box.min_z;
                max_x <= next_box.max_x;
                max_y <= next_box.max_y;
                max_z <= next_box.max_z;
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: track plane writes, check verdicts, predict on each box transfer
    always @(posedge clk)
    begin
        box_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_we === 1'b1)
            begin
                if (cfg_idx < NUM_PLANES)
                    plane_shadow[cfg_idx] = cfg_wdata;
                cfg_writes++;
            end

            if (done === 1'b1)
            begin
                if (verdict_queue.size() == 0)
                begin
                    report_mismatch("verdict with no box in flight");
                end
                else
                begin
                    logic want;
                    want = verdict_queue.pop_front();
                    if (outside !== want)
                        report_mismatch($sformatf("verdict %0d: outside %b, expected %b",
                                                  verdicts_seen, outside, want));
                    verdicts_seen++;
                    if (want)
                        culled_seen++;
                end
            end

            if (start === 1'b1 && busy === 1'b0)
            begin
                box_taken = 1'b1;
                verdict_queue.push_back(cull_verdict({min_x, min_y, min_z,
                                                      max_x, max_y, max_z}));
                boxes_taken++;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int          ph;
        int          idle_by_phase[4];
        plane_kind_e set_order[8];

        idle_by_phase = '{0, 85, 0, 12};
        set_order     = '{PLANES_SLAB, PLANES_SLANT, PLANES_RANDOM,
                          PLANES_EXTREME, PLANES_SLANT, PLANES_SLAB,
                          PLANES_EXTREME, PLANES_RANDOM};

        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Planes still zero after reset: every box must read culled
        queue_box(mk_box(0, 0, 0, 0, 0, 0));
        queue_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        queue_box(mk_box(500, 500, 500, -500, -500, -500));
        wait_drained();

        // Axis-aligned cube of half-size 100.0
        program_planes(make_planes(PLANES_SLAB, CUBE_HALF));
        queue_box(mk_box(-160, -160, -160, 160, 160, 160));
        queue_box(mk_box(2000, -10, -10, 3000, 10, 10));
        queue_box(mk_box(-3000, -10, -10, -2000, 10, 10));
        queue_box(mk_box(-10, 2000, -10, 10, 3000, 10));
        queue_box(mk_box(-10, -10, -3000, 10, 10, -2000));
        queue_box(mk_box(1000, -10, -10, 2000, 10, 10));
        // corner exactly on a face sums to zero and is not in
        queue_box(mk_box(1600, 0, 0, 1600, 0, 0));
        queue_box(mk_box(1599, 0, 0, 1599, 0, 0));
        queue_box(mk_box(0, 0, -1600, 0, 0, -1600));
        // min above max: corners still formed per axis
        queue_box(mk_box(160, 160, 160, -160, -160, -160));
        queue_box(mk_box(3000, 0, 0, -3000, 0, 0));
        queue_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        queue_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        queue_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        queue_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        queue_box(mk_box(0, 0, 0, 0, 0, 0));
        wait_drained();

        // Random boxes under changing plane sets and sender idling
        for (ph = 0; ph < 8; ph++)
        begin
            idle_pct = idle_by_phase[ph % 4];
            program_planes(make_planes(set_order[ph], $urandom_range(3000)));
            repeat (BOXES_PER_SET) queue_box(rand_box());
            wait_drained();
        end

        if (verdict_queue.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", verdict_queue.size()));

        $display("Checked %0d box verdicts (%0d culled, %0d kept) across %0d plane sets",
                 verdicts_seen, culled_seen, verdicts_seen - culled_seen, plane_sets);
        $display("%0d register writes incl. unused slots; sender idle 0, 12 and 85 pct",
                 cfg_writes);
        if (err_count == 0)
            $display("box_frustum_cull_unit test passed");
        else
            $display("box_frustum_cull_unit test failed");
        $finish;
    end

endmodule
